FILE: hdl/dttk_pkg.sv
// Package for the deadline timer: shared constants, register indexes and the divider status.
// It has no dependencies. Every module of the block imports it.
package dttk_pkg;

  // Field and register widths.
  localparam int unsigned DataW   = 64;
  localparam int unsigned PeriodW = 27;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ConstW  = 30;
  localparam int unsigned UsW     = 35;
  localparam int unsigned SliceW  = 18;
  localparam int unsigned PpW     = SliceW + ConstW;
  localparam int unsigned CntW    = 6;

  // Femtoseconds per microsecond.
  localparam logic [ConstW-1:0] FS_PER_US = 30'd1000000000;

  // Largest microsecond count whose femtosecond value still fits in 64 bits.
  localparam logic [DataW-1:0] MAX_US = 64'd18446744073;

  // Reset value of the tick period.
  localparam logic [PeriodW-1:0] PERIOD_RESET = 27'd69841279;

  // Half of the counter range for the wide and the narrow counter.
  localparam logic [DataW-1:0] HALF_WIDE   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DataW-1:0] HALF_NARROW = 64'h0000_0000_7FFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED    = 2'd0,
    CFG_PERIOD_FS  = 2'd1,
    CFG_IS_WIDE    = 2'd2
  } cfg_idx_e;

  // Input kinds carried in tuser.
  localparam logic OP_START = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Status that the divider returns to the sequencer.
  typedef struct packed {
    logic done;
    logic rem_nz;
  } div_status_t;

endpackage

FILE: hdl/deadline_timer_us_to_ticks_top.sv
// Top level of the deadline timer: configuration, sequencer, timer state and output register.
// Depends on dttk_pkg, dttk_mul and dttk_div.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser: opcode; tdata: microseconds, counter_now
//   m_axis    out        tdata: accepted, expired, interval_ticks
//   cfg       in         cfg_idx_i selects enabled, period_fs, counter_is_wide
//
// A start that passes the input checks goes through the shared multiplier, the divider
// (one bit a cycle) with its load, rounding, the range check and the output register
// before ready returns. A rejected start goes straight to the output register, a check
// through the check step first. The output register holds a result until it is taken
// while the next item is accepted; the sequencer waits at its last step while the output is
// still full. Reset is asynchronous and clears the timer state; no clearing pass is needed.
module deadline_timer_us_to_ticks_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port.
  input  logic                           cfg_we_i,
  input  logic [dttk_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dttk_pkg::PeriodW-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [127:0]                   s_axis_tdata_i,  // [63:0] microseconds,
                                                          // [127:64] counter_now
  input  logic                           s_axis_tuser_i,  // [0] opcode
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [71:0]                    m_axis_tdata_o   // [0] accepted, [1] expired,
                                                          // [65:2] interval_ticks, [71:66] zero
);
  import dttk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LIMIT,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic               enabled_q;
  logic [PeriodW-1:0] period_q;
  logic               wide_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      period_q  <= PERIOD_RESET;
      wide_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLED:   enabled_q <= cfg_wdata_i[0];
        CFG_PERIOD_FS: period_q  <= cfg_wdata_i;
        CFG_IS_WIDE:   wide_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic [DataW-1:0]   now_q;
  logic [DataW-1:0]   ticks_q;
  logic [DataW-1:0]   start_cnt_q;
  logic [DataW-1:0]   dur_cnt_q;
  logic               expired_q;
  logic               armed_q;
  logic               res_acc_q;
  logic               res_exp_q;
  logic [DataW-1:0]   res_dur_q;
  logic               out_valid_q;
  logic [71:0]        out_data_q;

  logic               in_accept;
  logic [DataW-1:0]   in_us;
  logic [DataW-1:0]   in_now;
  logic               start_bad;
  logic               mul_start;
  logic               mul_done;
  logic [DataW-1:0]   product;
  div_status_t        div_status;
  logic [DataW-1:0]   quotient;
  logic [DataW-1:0]   half_mask;
  logic [DataW-1:0]   elapsed_raw;
  logic [DataW-1:0]   elapsed;
  logic               out_free;

  assign in_us  = s_axis_tdata_i[63:0];
  assign in_now = wide_q ? s_axis_tdata_i[127:64] : {32'd0, s_axis_tdata_i[95:64]};

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // A start is turned away at once when it cannot produce a valid duration.
  assign start_bad = !enabled_q || (in_us == '0) || (in_us > MAX_US) || (period_q == '0);
  assign mul_start = in_accept && (s_axis_tuser_i == OP_START) && !start_bad;

  assign half_mask   = wide_q ? HALF_WIDE : HALF_NARROW;
  assign elapsed_raw = now_q - start_cnt_q;
  assign elapsed     = wide_q ? elapsed_raw : {32'd0, elapsed_raw[31:0]};
  assign out_free    = !out_valid_q || m_axis_tready_i;

  dttk_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .us_i      (in_us[UsW-1:0]),
    .done_o    (mul_done),
    .product_o (product)
  );

  dttk_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mul_done),
    .dividend_i (product),
    .divisor_i  (period_q),
    .status_o   (div_status),
    .quotient_o (quotient)
  );

  // Sequencer, timer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_cnt_q <= '0;
      dur_cnt_q   <= '0;
      expired_q   <= 1'b0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result may replace one that is taken in the same cycle.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            now_q     <= in_now;
            res_acc_q <= 1'b0;
            res_exp_q <= 1'b0;
            res_dur_q <= '0;
            if (s_axis_tuser_i == OP_CHECK) begin
              state_q <= ST_CHECK;
            end else if (start_bad) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Round up on a remainder; a zero quotient counts as one tick.
          if (div_status.done) begin
            if ((quotient == '0) && !div_status.rem_nz) begin
              ticks_q <= DataW'(1);
            end else begin
              ticks_q <= quotient + DataW'(div_status.rem_nz);
            end
            state_q <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          if (ticks_q <= half_mask) begin
            start_cnt_q <= now_q;
            dur_cnt_q   <= ticks_q;
            expired_q   <= 1'b0;
            armed_q     <= 1'b1;
            res_acc_q   <= 1'b1;
            res_dur_q   <= ticks_q;
          end
          state_q <= ST_DONE;
        end
        ST_CHECK: begin
          if (!enabled_q || !armed_q || expired_q) begin
            res_exp_q <= 1'b1;
          end else if (elapsed >= dur_cnt_q) begin
            expired_q <= 1'b1;
            res_exp_q <= 1'b1;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data_q  <= {6'd0, res_dur_q, res_exp_q, res_acc_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  // A result never reports an accepted start and an expiry together.
  a_acc_exp_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("accepted and expired both set");

  // An accepted start carries a nonzero duration below half of the wide counter range.
  a_acc_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[0]) |->
      (m_axis_tdata_o[65:2] != 64'd0) && !m_axis_tdata_o[65])
    else $error("accepted start with bad duration");

  // Rejected starts and checks carry a zero duration.
  a_nacc_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[0]) |-> (m_axis_tdata_o[65:2] == 64'd0))
    else $error("nonzero duration without an accepted start");

  // Once a deadline is armed it stays armed until reset.
  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(armed_q))
    else $error("armed flag cleared");
`endif

endmodule

FILE: hdl/dttk_mul.sv
// Scales a microsecond count to femtoseconds in low, high and sum phases.
// It uses one 18 by 30 bit multiplier twice. Depends on dttk_pkg.
module dttk_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dttk_pkg::UsW-1:0]    us_i,
  output logic                        done_o,
  output logic [dttk_pkg::DataW-1:0]  product_o
);
  import dttk_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LO,
    PH_HI,
    PH_SUM
  } phase_e;

  phase_e             phase_q;
  logic               done_q;
  logic [UsW-1:0]     us_q;
  logic [PpW-1:0]     pp_q;
  logic [DataW-1:0]   acc_q;
  logic [SliceW-1:0]  mul_a;
  logic [PpW-1:0]     pp_d;
  logic [DataW-1:0]   pp_shift;

  // The low slice goes through first, then the high slice.
  assign mul_a = (phase_q == PH_LO) ? us_q[SliceW-1:0]
                                    : {1'b0, us_q[UsW-1:SliceW]};
  assign pp_d = PpW'(mul_a) * PpW'(FS_PER_US);
  assign pp_shift = DataW'({pp_q, SliceW'(0)});

  // Phase sequencer and accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (phase_q == PH_SUM);
      unique case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            us_q    <= us_i;
            phase_q <= PH_LO;
          end
        end
        PH_LO: begin
          pp_q    <= pp_d;
          phase_q <= PH_HI;
        end
        PH_HI: begin
          acc_q   <= DataW'(pp_q);
          pp_q    <= pp_d;
          phase_q <= PH_SUM;
        end
        PH_SUM: begin
          acc_q   <= acc_q + pp_shift;
          phase_q <= PH_IDLE;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

FILE: hdl/dttk_div.sv
// Restoring divider: a 64-bit dividend over a 27-bit divisor, one quotient bit a cycle.
// It reports whether a remainder is left for rounding up. Depends on dttk_pkg.
module dttk_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dttk_pkg::DataW-1:0]    dividend_i,
  input  logic [dttk_pkg::PeriodW-1:0]  divisor_i,
  output dttk_pkg::div_status_t         status_o,
  output logic [dttk_pkg::DataW-1:0]    quotient_o
);
  import dttk_pkg::*;

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DataW-1:0]   work_q;
  logic [PeriodW-1:0] rem_q;
  logic [PeriodW-1:0] dsr_q;
  logic [PeriodW:0]   trial;
  logic [PeriodW:0]   diff;
  logic               fits;

  // One shift and trial subtraction per cycle.
  assign trial = {rem_q, work_q[DataW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // The last quotient bit lands at the same edge that raises done.
      done_q <= busy_q && (cnt_q == CntW'(DataW - 1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        work_q <= dividend_i;
        rem_q  <= '0;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        // The quotient bits replace the dividend bits from the right.
        work_q <= {work_q[DataW-2:0], fits};
        rem_q  <= fits ? diff[PeriodW-1:0] : trial[PeriodW-1:0];
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign status_o.done   = done_q;
  assign status_o.rem_nz = (rem_q != '0);
  assign quotient_o      = work_q;

endmodule
